### rtl/core/bf3_pkg.sv
package bf3_pkg;

	// Fixed field widths of the pixel stream and the size registers.
	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	// Sum of nine pixels plus the rounding term fits in 12 bits (max 2299).
	localparam int SUM_W = 12;

	// Defaults for the largest supported frame.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Reset value of both size registers.
	localparam logic [CFG_W-1:0] CFG_SIZE_RST = 11'd512;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Reciprocal of nine in 16 fractional bits, rounded up. For sums below
	// 2300 the error stays under 1/100 and the floor is exact.
	localparam logic [12:0] RECIP9 = 13'd7282;

	// Rounded mean of nine pixels: (sum + 4) / 9.
	function automatic logic [PIX_W-1:0] div9_round(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] biased;
		logic [SUM_W+13-1:0] prod;
		begin
			biased = sum + SUM_W'(4);
			prod = (SUM_W+13)'(biased) * (SUM_W+13)'(RECIP9);
			div9_round = prod[16 +: PIX_W];
		end
	endfunction

endpackage

### rtl/core/bf3_line_buf.sv
module bf3_line_buf
	import bf3_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [PIX_W-1:0]         rd_top,
	output logic [PIX_W-1:0]         rd_mid,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [PIX_W-1:0]         wr_mid,
	input  logic [PIX_W-1:0]         wr_x,
	output logic                     busy
);

	localparam int AW = $clog2(DEPTH);

	// Each entry holds the older line in the upper byte and the newer one below.
	logic [2*PIX_W-1:0] mem [DEPTH];
	logic [2*PIX_W-1:0] rd_q;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;

	// Zero both lines once after reset, one column per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= {wr_mid, wr_x};
		end
		// A read of the column being written in the same cycle takes the new data.
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= {wr_mid, wr_x};
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_top = rd_q[PIX_W +: PIX_W];
	assign rd_mid = rd_q[0 +: PIX_W];
	assign busy = clr_q;

endmodule

### rtl/core/bf3_window.sv
module bf3_window
	import bf3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [PIX_W-1:0] top,
	input  logic [PIX_W-1:0] mid,
	input  logic [PIX_W-1:0] bot,
	output logic [SUM_W-1:0] sum_next,
	output logic [PIX_W-1:0] center_next
);

	// Three columns of top, middle, bottom; the newest column sits at 6..8.
	logic [PIX_W-1:0] win_q [9];
	logic [SUM_W-1:0] col1_sum;
	logic [SUM_W-1:0] col2_sum;
	logic [SUM_W-1:0] col3_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= win_q[i+3];
			end
			win_q[6] <= top;
			win_q[7] <= mid;
			win_q[8] <= bot;
		end
	end

	// Sum over the window as it stands after the shift.
	assign col1_sum = SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);
	assign col2_sum = SUM_W'(win_q[6]) + SUM_W'(win_q[7]) + SUM_W'(win_q[8]);
	assign col3_sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
	assign sum_next = col1_sum + col2_sum + col3_sum;
	assign center_next = win_q[7];

endmodule

### rtl/core/box_filter_3x3.sv
// Path: the push that emits a pixel loads stage 1, then stage 2, then the output register;
// that push comes frame_width+1 pushes after the pixel itself entered.
// Throughput: one word per clock unless output stalls; line store read and write per column.
// Reset: arst_n clears all control state, then the line stores are zeroed column by column,
// during which s_axis_tready stays low; configuration writes are taken throughout.
module box_filter_3x3
	import bf3_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Input stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
	input  logic                 s_axis_tuser,   // [0] kind (1 = flush word)
	// Output stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
	output logic                 m_axis_tlast    // frame_end
);

	// Column and row counters index below the maximum sizes; SW holds the
	// effective width plus one (the fill target), HW the effective height.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SW = $clog2(MAX_WIDTH + 2);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// Size registers.
	logic [CFG_W-1:0] cfg_width_q;
	logic [CFG_W-1:0] cfg_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q <= CFG_SIZE_RST;
			cfg_height_q <= CFG_SIZE_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_FRAME_WIDTH: cfg_width_q <= cfg_data;
				REG_FRAME_HEIGHT: cfg_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The sizes in use are the register values clamped to [3, maximum].
	logic [SW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	always_comb begin
		if (cfg_width_q < CFG_W'(3)) begin
			eff_w = SW'(3);
		end else if (int'(cfg_width_q) > MAX_WIDTH) begin
			eff_w = SW'(MAX_WIDTH);
		end else begin
			eff_w = SW'(cfg_width_q);
		end
		if (cfg_height_q < CFG_W'(3)) begin
			eff_h = HW'(3);
		end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(cfg_height_q);
		end
	end

	// Position counters and the fill count. The input side points at the
	// column the next pixel lands in; the output side at the next pixel to
	// leave, one line plus one pixel behind.
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [SW-1:0] fill_q;

	// Pipeline control.
	logic v1_s1;
	logic v2_s2;
	logic vo_q;
	logic out_free;
	logic adv2;
	logic adv1;
	logic done1;
	logic clr_busy;

	logic accept;
	logic is_flush;
	logic push;
	logic emit;
	logic interior;
	logic last;

	logic [SW-1:0] w_plus1;
	logic [SW-1:0] in_col_inc;
	logic [HW-1:0] in_row_inc;
	logic [SW-1:0] out_col_inc;
	logic [HW-1:0] out_row_inc;

	// Stage 1: the pushed pixel and what its result will need.
	logic [PIX_W-1:0] x_s1;
	logic [CW-1:0]    col_s1;
	logic             emit_s1;
	logic             interior_s1;
	logic             last_s1;

	// Stage 2: window sum and center of an emitted pixel.
	logic [SUM_W-1:0] sum_s2;
	logic [PIX_W-1:0] center_s2;
	logic             interior_s2;
	logic             last_s2;

	logic [PIX_W-1:0] out_data_q;
	logic             out_last_q;

	logic [PIX_W-1:0] lb_top;
	logic [PIX_W-1:0] lb_mid;
	logic [SUM_W-1:0] win_sum;
	logic [PIX_W-1:0] win_center;

	// Each stage moves when the one after it is empty or moving. A word that
	// only fills the pipe finishes in stage 1 and never waits on the output,
	// so new words keep coming in while a finished result waits to be taken.
	assign out_free = !vo_q || m_axis_tready;
	assign adv2 = !v2_s2 || out_free;
	assign adv1 = !v1_s1 || !emit_s1 || adv2;
	assign done1 = v1_s1 && adv1;

	assign s_axis_tready = adv1 && !clr_busy;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_flush = s_axis_tuser;

	// A flush word with an empty pipe is taken and dropped; otherwise it pushes
	// a zero pixel.
	assign push = accept && (!is_flush || fill_q != '0);

	assign w_plus1 = eff_w + 1'b1;
	assign emit = !(fill_q < w_plus1);

	assign in_col_inc = SW'(in_col_q) + 1'b1;
	assign in_row_inc = HW'(in_row_q) + 1'b1;
	assign out_col_inc = SW'(out_col_q) + 1'b1;
	assign out_row_inc = HW'(out_row_q) + 1'b1;

	// Inner frame: not the first or last row, not the first or last column.
	assign interior = (out_row_q != '0) && (out_row_inc < eff_h) &&
		(out_col_q != '0) && (out_col_inc < eff_w);
	assign last = (out_row_inc == eff_h) && (out_col_inc == eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			if (is_flush && emit && last) begin
				// The last pixel of the frame left on a flush: start clean.
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				fill_q <= '0;
			end else begin
				if (in_col_inc >= eff_w) begin
					in_col_q <= '0;
					if (in_row_inc >= eff_h) begin
						in_row_q <= '0;
					end else begin
						in_row_q <= in_row_inc[RW-1:0];
					end
				end else begin
					in_col_q <= in_col_inc[CW-1:0];
				end
				if (emit) begin
					if (out_col_inc >= eff_w) begin
						out_col_q <= '0;
						if (out_row_inc >= eff_h) begin
							out_row_q <= '0;
						end else begin
							out_row_q <= out_row_inc[RW-1:0];
						end
					end else begin
						out_col_q <= out_col_inc[CW-1:0];
					end
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// Two previous lines; the read at the input column is issued on the push.
	bf3_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (push),
		.rd_addr (in_col_q),
		.rd_top  (lb_top),
		.rd_mid  (lb_mid),
		.wr_en   (done1),
		.wr_addr (col_s1),
		.wr_mid  (lb_mid),
		.wr_x    (x_s1),
		.busy    (clr_busy)
	);

	// 3x3 neighborhood, shifted by one column for every push.
	bf3_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift       (done1),
		.top         (lb_top),
		.mid         (lb_mid),
		.bot         (x_s1),
		.sum_next    (win_sum),
		.center_next (win_center)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_s1 <= push;
			end
			if (adv2) begin
				v2_s2 <= done1 && emit_s1;
			end
			if (out_free) begin
				vo_q <= v2_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			x_s1 <= is_flush ? '0 : s_axis_tdata;
			col_s1 <= in_col_q;
			emit_s1 <= emit;
			interior_s1 <= interior;
			last_s1 <= last;
		end
		if (done1 && emit_s1) begin
			sum_s2 <= win_sum;
			center_s2 <= win_center;
			interior_s2 <= interior_s1;
			last_s2 <= last_s1;
		end
		if (out_free && v2_s2) begin
			out_data_q <= interior_s2 ? div9_round(sum_s2) : center_s2;
			out_last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

`ifndef SYNTHESIS
	// No word enters while the line stores are being zeroed.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_axis_tready)
		else $error("word accepted during line store clear");

	// The fill count never runs past the largest fill target.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_WIDTH + 1)
		else $error("fill count out of range");

	// A result enters stage 2 only from a finished emitting push.
	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v2_s2) |-> $past(v1_s1 && emit_s1))
		else $error("stage 2 loaded without a source");

	// A flush that emits the frame's last pixel clears the fill count and the input column.
	a_flush_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_flush && emit && last) |=> (fill_q == '0 && in_col_q == '0))
		else $error("flush at frame end did not reset counters");
`endif

endmodule
